// File: hdl/psfp_pkg.sv
// psfp_pkg: shared constants and types of the particulate sensor frame parser
// no dependencies; imported by every psfp module and the core top level
`default_nettype none

package psfp_pkg;

    localparam int ByteWidth  = 8;
    localparam int WordWidth  = 16;
    localparam int PosWidth   = 5;

    // header bytes and frame positions
    localparam logic [ByteWidth-1:0] HdrFirst  = 8'h42;
    localparam logic [ByteWidth-1:0] HdrSecond = 8'h4D;
    localparam logic [PosWidth-1:0]  HdrPos2   = 5'd1;
    localparam logic [PosWidth-1:0]  ShortLast = 5'd7;
    localparam logic [PosWidth-1:0]  SumLast   = 5'd29;
    localparam logic [PosWidth-1:0]  ChkHiPos  = 5'd30;
    localparam logic [PosWidth-1:0]  FrameLast = 5'd31;

    // payload bytes kept from the frame: offsets 6..15
    localparam logic [PosWidth-1:0]  KeepFirst = 5'd6;
    localparam logic [PosWidth-1:0]  KeepLast  = 5'd15;
    localparam int KeepCount = 10;
    localparam int KeepIdxWidth = 4;

    typedef struct packed {
        logic                 valid;
        logic [WordWidth-1:0] pm25_standard;
        logic [WordWidth-1:0] pm1_ambient;
        logic [WordWidth-1:0] pm25_ambient;
        logic [WordWidth-1:0] pm10_ambient;
    } psfp_result_t;

endpackage

`default_nettype wire

// File: hdl/psfp_in_stage.sv
// psfp_in_stage: input register holding one received byte request
// depends on psfp_pkg
`default_nettype none

module psfp_in_stage
    import psfp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [ByteWidth-1:0] s_tdata,
    input  wire logic                 advance_i,
    output logic                      valid_o,
    output logic [ByteWidth-1:0]      byte_o
);

    logic                 valid_reg;
    logic [ByteWidth-1:0] byte_reg;

    // slot frees when the parser takes the held byte
    assign s_tready = !valid_reg || advance_i;
    assign valid_o  = valid_reg;
    assign byte_o   = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (advance_i) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule

`default_nettype wire

// File: hdl/psfp_parser.sv
// psfp_parser: header hunt, short reply drop, running checksum and field capture
// depends on psfp_pkg; produces a psfp_result_t for the output register
`default_nettype none

module psfp_parser
    import psfp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 take_i,
    input  wire logic [ByteWidth-1:0] byte_i,
    output psfp_result_t              res_o
);

    logic [PosWidth-1:0]  count_reg, count_next;
    logic                 skipped_reg, skipped_next;
    logic [WordWidth-1:0] sum_reg, sum_next;
    logic [ByteWidth-1:0] hdr0_reg;
    logic [ByteWidth-1:0] chk_hi_reg;
    logic [ByteWidth-1:0] keep_reg [KeepCount];

    logic                 mismatch;
    logic [WordWidth-1:0] sum_add;
    logic [PosWidth-1:0]  keep_off;

    assign mismatch = (count_reg == HdrPos2) &&
                      ((hdr0_reg != HdrFirst) || (byte_i != HdrSecond));
    assign sum_add  = (count_reg <= SumLast) ?
                      sum_reg + {{(WordWidth-ByteWidth){1'b0}}, byte_i} : sum_reg;
    assign keep_off = count_reg - KeepFirst;

    always_comb begin
        count_next   = count_reg;
        skipped_next = skipped_reg;
        sum_next     = sum_reg;
        res_o        = '0;
        res_o.pm25_standard = {keep_reg[0], keep_reg[1]};
        res_o.pm1_ambient   = {keep_reg[4], keep_reg[5]};
        res_o.pm25_ambient  = {keep_reg[6], keep_reg[7]};
        res_o.pm10_ambient  = {keep_reg[8], keep_reg[9]};
        if (take_i) begin
            if (mismatch) begin
                // slide the window: new byte becomes byte 0
                count_next = HdrPos2;
                sum_next   = {{(WordWidth-ByteWidth){1'b0}}, byte_i};
            end else if (!skipped_reg && count_reg == ShortLast) begin
                skipped_next = 1'b1;
                count_next   = '0;
                sum_next     = '0;
            end else if (count_reg != FrameLast) begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_add;
            end else begin
                count_next  = '0;
                sum_next    = '0;
                res_o.valid = ({chk_hi_reg, byte_i} == sum_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            skipped_reg <= 1'b0;
            sum_reg     <= '0;
        end else begin
            count_reg   <= count_next;
            skipped_reg <= skipped_next;
            sum_reg     <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_i) begin
            if (count_reg == '0 || mismatch) begin
                hdr0_reg <= byte_i;
            end
            if (count_reg == ChkHiPos) begin
                chk_hi_reg <= byte_i;
            end
            if (count_reg >= KeepFirst && count_reg <= KeepLast) begin
                keep_reg[keep_off[KeepIdxWidth-1:0]] <= byte_i;
            end
        end
    end

    // a result closes the frame
    a_result_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        res_o.valid |=> count_reg == '0 && sum_reg == '0)
        else $error("count not restarted after result");

    // no result before the short reply has gone
    a_result_after_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        res_o.valid |-> skipped_reg)
        else $error("result before short reply dropped");

    // short reply drop happens once
    a_skip_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        skipped_reg |=> skipped_reg)
        else $error("short reply flag cleared");

    // a bad header leaves exactly one byte collected
    a_slide_one: assert property (@(posedge aclk) disable iff (!aresetn)
        take_i && mismatch |=> count_reg == HdrPos2)
        else $error("window slide lost the byte");

endmodule

`default_nettype wire

// File: hdl/psfp_out_stage.sv
// psfp_out_stage: result register feeding the master stream port
// depends on psfp_pkg
`default_nettype none

module psfp_out_stage
    import psfp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire psfp_result_t      res_i,
    output logic                   advance_o,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [4*WordWidth-1:0] m_tdata
);

    logic                     valid_reg;
    logic [4*WordWidth-1:0]   data_reg;

    assign advance_o = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance_o) begin
            valid_reg <= res_i.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance_o && res_i.valid) begin
            data_reg <= {res_i.pm10_ambient, res_i.pm25_ambient,
                         res_i.pm1_ambient, res_i.pm25_standard};
        end
    end

endmodule

`default_nettype wire

// File: hdl/particulate_sensor_frame_parser_core.sv
// particulate_sensor_frame_parser_core: top level of the sensor frame parser
// depends on psfp_pkg, psfp_in_stage, psfp_parser, psfp_out_stage
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata[7:0] rx_byte
//  m_        out  m_tvalid/m_tready  m_tdata[63:0] four measurement words
//
// one byte per cycle sustained while the result register is not stalled; a byte
// goes input register -> parser state, and the result of a frame's last byte
// is registered in the result register once that byte leaves the input register,
// raising m_tvalid; reset clears the valid flags, byte count, checksum and
// short reply flag; a stalled result register holds the parser; s_tready then
// drops once the input register is full
`default_nettype none

module particulate_sensor_frame_parser_core
    import psfp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // slave side: received serial bytes
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [ByteWidth-1:0] s_tdata,   // [7:0] rx_byte
    // master side: parsed measurements
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [4*WordWidth-1:0]    m_tdata    // [15:0] pm25_standard,
                                                 // [31:16] pm1_ambient,
                                                 // [47:32] pm25_ambient,
                                                 // [63:48] pm10_ambient
);

    logic                 advance;     // result register can take a new value
    logic                 held_valid;  // input register holds a byte
    logic [ByteWidth-1:0] held_byte;
    logic                 take;        // parser consumes the held byte
    psfp_result_t         result;

    assign take = held_valid && advance;

    // input register
    psfp_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .advance_i (advance),
        .valid_o   (held_valid),
        .byte_o    (held_byte)
    );

    // frame state and checksum
    psfp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take_i  (take),
        .byte_i  (held_byte),
        .res_o   (result)
    );

    // result register
    psfp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_i     (result),
        .advance_o (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
